// ===== src/spnb_pkg.sv =====
// Shared types and constants for the nine-bit data/command packer.
package spnb_pkg;

    // Bits a pending partial output byte can hold.
    localparam int unsigned PEND_W = 7;

    // Symbol position that closes a group of eight.
    localparam logic [2:0] GROUP_LAST = 3'd7;

    // Output bytes produced by one full group of eight symbols.
    localparam logic [3:0] GROUP_BYTES = 4'd9;

    // Work handed from the front to the back: emit 'count' words,
    // first then second then zeros; flag the final one when 'last' is set.
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [3:0] count;
        logic       last;
    } spnb_job_t;

endpackage

// ===== src/spnb_front.sv =====
// Front end: accepts command bytes, forms symbols and packs them into jobs.
module spnb_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_command,
    input  logic                 queue_full,
    output logic                 push,
    output spnb_pkg::spnb_job_t  job
);

    logic [spnb_pkg::PEND_W-1:0] pend_reg;
    logic [spnb_pkg::PEND_W-1:0] pend_next;
    logic [2:0]                  pos_reg;
    logic [2:0]                  pos_next;
    logic                        start_reg;
    logic                        start_next;
    logic [15:0]                 sym_w;
    logic [15:0]                 win_w;
    logic                        accept;

    assign src_stall = queue_full;
    assign accept    = src_valid && !queue_full;
    assign push      = accept;

    // Place the new symbol right after the pending bits, MSB first.
    always_comb
    begin
        sym_w = {7'b0, !start_reg, data_byte} << (3'd7 - pos_reg);
        win_w = {pend_reg, 9'b0} | sym_w;
    end

    always_comb
    begin
        job.first  = win_w[15:8];
        job.second = win_w[7:0];
        job.last   = end_of_command;
        priority if (pos_reg == spnb_pkg::GROUP_LAST)
        begin
            job.count = 4'd2;
        end
        else if (end_of_command)
        begin
            // leftover byte plus zero padding up to nine bytes per group
            job.count = spnb_pkg::GROUP_BYTES - {1'b0, pos_reg};
        end
        else
        begin
            job.count = 4'd1;
        end
    end

    always_comb
    begin
        pend_next  = pend_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        if (accept)
        begin
            priority if (end_of_command)
            begin
                pend_next  = '0;
                pos_next   = '0;
                start_next = 1'b1;
            end
            else
            begin
                pend_next  = (pos_reg == spnb_pkg::GROUP_LAST) ? '0 : win_w[7:1];
                pos_next   = pos_reg + 3'd1;
                start_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            pos_reg   <= '0;
            start_reg <= 1'b1;
        end
        else
        begin
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (pos_reg == 3'd0 && pend_reg == '0))
        else $error("command start with leftover packed bits");

endmodule

// ===== src/spnb_fifo.sv =====
// Two-entry job queue between the front and back ends.
module spnb_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  spnb_pkg::spnb_job_t  push_job,
    output logic                 full,
    input  logic                 pop,
    output logic                 nonempty,
    output spnb_pkg::spnb_job_t  head
);

    spnb_pkg::spnb_job_t mem_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign nonempty = (cnt_reg != 2'd0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !nonempty))
        else $error("job queue underflow");

endmodule

// ===== src/spnb_back.sv =====
// Back end: walks each job and drives packed words into the output register.
module spnb_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  spnb_pkg::spnb_job_t  job,
    output logic                 pop,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output logic [7:0]           out_byte,
    output logic                 last_byte
);

    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;
    logic       load;
    logic       final_word;

    assign load       = job_valid && (!valid_reg || !dst_stall);
    assign final_word = (idx_reg == job.count - 4'd1);
    assign pop        = load && final_word;

    assign dst_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = job.last && final_word;
            unique case (idx_reg)
                4'd0:    byte_next = job.first;
                4'd1:    byte_next = job.second;
                default: byte_next = 8'h00;
            endcase
            // advance within the job, or drop back for the next one
            idx_next = final_word ? 4'd0 : idx_reg + 4'd1;
        end
        else if (!dst_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (job.count != 4'd0 && idx_reg < job.count))
        else $error("word index outside current job");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !job_valid |-> idx_reg == 4'd0)
        else $error("word index left over with no job queued");

endmodule

// ===== src/spi_nine_bit_dc_packer.sv =====
// Top level of the nine-bit data/command packer: front end, job queue, back end.
// The first word of a byte is registered in the job queue, then in the output register.
// Throughput: one output word per cycle while dst_stall is low; an input byte yields
// as many words as its job count (1 or 2, up to 9 on the final byte), set by the front end.
// Sustained: 9 output words per 8 input bytes; a two-entry job queue decouples input.
// Reset: asynchronous, active low; clears packing state and empties the queue.
module spi_nine_bit_dc_packer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_command,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] out_byte,
    output logic       last_byte
);

    spnb_pkg::spnb_job_t push_job;
    spnb_pkg::spnb_job_t head_job;
    logic                push;
    logic                pop;
    logic                full;
    logic                nonempty;

    spnb_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .data_byte      (data_byte),
        .end_of_command (end_of_command),
        .queue_full     (full),
        .push           (push),
        .job            (push_job)
    );

    spnb_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .head     (head_job)
    );

    spnb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (nonempty),
        .job       (head_job),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule
